// ===== rtl/grid_interpolator_5d_defines.svh =====
// Assertion macros for the grid_interpolator_5d checker.
// No dependencies; included by the checker file only.
`ifndef GRID_INTERPOLATOR_5D_DEFINES_SVH
`define GRID_INTERPOLATOR_5D_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GI5_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GI5_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/gi5_pkg.sv =====
// Shared constants, codes and types for the 5-D grid interpolator.
// No dependencies; used by gi5_div, grid_interpolator_5d, gi5_checker and the bench.
`default_nettype none

package gi5_pkg;

  localparam int NUM_AXES = 5;

  // opcodes of an input transfer
  localparam logic [1:0] OP_LOAD_AXIS = 2'd0;
  localparam logic [1:0] OP_LOAD_GRID = 2'd1;
  localparam logic [1:0] OP_QUERY     = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_INDEX = 2'd1;
  localparam logic [1:0] ST_SAT       = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_THETA   = 3'd0;
  localparam logic [2:0] CFG_MACH    = 3'd1;
  localparam logic [2:0] CFG_TAU     = 3'd2;
  localparam logic [2:0] CFG_ALPHA_N = 3'd3;
  localparam logic [2:0] CFG_ALPHA_T = 3'd4;

  localparam logic [3:0] POINTS_RESET = 4'd8;

  // Q1.16 (17 bits), so 1.0 is representable
  localparam logic [16:0] ONE_Q16 = 17'd65536;
  localparam int          DIV_STEPS = 16;

  // divider request and response
  typedef struct packed {
    logic        start;
    logic [31:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/gi5_ram.sv =====
// Simple dual-port RAM: one write port, one read port with registered data.
// Depends on nothing; holds the axis tables and the coefficient grid.
`default_nettype none

module gi5_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/gi5_div.sv =====
// Restoring divider for axis fractions, one quotient bit per cycle.
// Depends on gi5_pkg (request and response types); num must be below den.
`default_nettype none

module gi5_div (
  input  logic              clk,
  input  logic              rst_n,
  input  gi5_pkg::div_req_t req,
  output gi5_pkg::div_rsp_t rsp
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] den_r, den_nxt;
  logic [15:0] quot_r, quot_nxt;
  logic [32:0] rem_sh;
  logic        ge;

  // one shift-subtract step
  assign rem_sh = {rem_r, 1'b0};
  assign ge     = rem_sh >= {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quot_nxt = quot_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 5'(gi5_pkg::DIV_STEPS);
      rem_nxt  = req.num;
      den_nxt  = req.den;
      quot_nxt = '0;
    end else if (busy_r) begin
      rem_nxt  = ge ? 32'(rem_sh - {1'b0, den_r}) : rem_sh[31:0];
      quot_nxt = {quot_r[14:0], ge};
      cnt_nxt  = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    quot_r <= quot_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule

`default_nettype wire

// ===== rtl/gi5_mul.sv =====
// Shared registered multiplier for corner weights and grid products.
// Depends on nothing; the product is registered and appears in the cycle after the operands.
`default_nettype none

module gi5_mul (
  input  logic               clk,
  input  logic signed [17:0] a,
  input  logic signed [32:0] b,
  output logic signed [50:0] prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end

endmodule

`default_nettype wire

// ===== rtl/grid_interpolator_5d.sv =====
// Top level of the 5-D multilinear grid interpolator: sequencer and stores.
// Depends on gi5_pkg, gi5_ram, gi5_div and gi5_mul.
//
// Usage: one input channel (in_valid/in_ready) carries loads and queries,
// one result channel (out_valid/out_ready) returns exactly one result per
// input transfer. The cfg_ channel writes the five axis point counts and is
// always ready; write it only while the block is idle.
// Loads (axis point or grid pair) write at the input transfer and pass
// through S_DONE to the output register; the next item can be taken once
// S_DONE has handed its result over. A query works the axes in turn: per
// axis it reads the end points, clamps, searches for the interval (up to
// AXIS_MAX - 1 steps) and, when the point lies strictly inside an interval,
// runs the one-bit-a-cycle divider; then it sweeps 32 corners on the single
// shared multiplier (one product per weight factor, then the two table
// products), and finally rounds and hands over the result.
// One item is in work at a time; in_ready is high only when idle. A result
// waits in the output register while out_ready is low, and the next item
// is taken meanwhile; its own result waits until that register frees.
// Reset (rst_n low, synchronous) sets all counts to 8 and empties the
// output; table contents are kept and are undefined until loaded.
`default_nettype none

module grid_interpolator_5d #(
  parameter int AXIS_MAX   = 8,
  parameter int GRID_WORDS = 32768
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [2:0]  in_axis_select,
  input  logic [14:0] in_entry_index,
  input  logic signed [31:0] in_axis_value,
  input  logic signed [31:0] in_cn_value,
  input  logic signed [31:0] in_ct_value,
  input  logic signed [31:0] in_query_theta,
  input  logic signed [31:0] in_query_mach,
  input  logic signed [31:0] in_query_tau,
  input  logic signed [31:0] in_query_alpha_n,
  input  logic signed [31:0] in_query_alpha_t,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] out_cn_result,
  output logic signed [31:0] out_ct_result,
  output logic [1:0]  out_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [3:0]  cfg_data
);

  localparam int NAX  = gi5_pkg::NUM_AXES;
  localparam int LW   = $clog2(AXIS_MAX);
  localparam int CW   = $clog2(AXIS_MAX + 1);
  localparam int AXW  = $clog2(NAX * AXIS_MAX);
  localparam int GW   = $clog2(GRID_WORDS);
  localparam int IDXW = NAX * LW;
  localparam int IW   = ((IDXW > GW) ? IDXW : GW) + 1;
  localparam int EW   = ((15 > GW) ? 15 : GW) + 1;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_AX_F   = 5'd1;
  localparam logic [4:0] S_AX_L   = 5'd2;
  localparam logic [4:0] S_AX_C   = 5'd3;
  localparam logic [4:0] S_SC_RD  = 5'd4;
  localparam logic [4:0] S_SC_CMP = 5'd5;
  localparam logic [4:0] S_PT_LO  = 5'd6;
  localparam logic [4:0] S_PT_HI  = 5'd7;
  localparam logic [4:0] S_PT_W   = 5'd8;
  localparam logic [4:0] S_DIV    = 5'd9;
  localparam logic [4:0] S_W_MUL  = 5'd10;
  localparam logic [4:0] S_W_RND  = 5'd11;
  localparam logic [4:0] S_CN_MUL = 5'd12;
  localparam logic [4:0] S_CT_MUL = 5'd13;
  localparam logic [4:0] S_CT_ACC = 5'd14;
  localparam logic [4:0] S_FIN    = 5'd15;
  localparam logic [4:0] S_DONE   = 5'd16;

  // count in use: register clamped to [2, AXIS_MAX]
  function automatic logic [CW-1:0] used_count(input logic [3:0] r);
    logic [4:0] rr;
    rr = {1'b0, r};
    if (rr < 5'd2) return CW'(2);
    else if (rr > 5'(AXIS_MAX)) return CW'(AXIS_MAX);
    return CW'(rr);
  endfunction

  // round the Q24.32 sum to Q16.16 with saturation, flag in the top bit
  function automatic logic [32:0] finish_q16(input logic signed [55:0] s);
    logic signed [55:0] t;
    logic signed [39:0] r;
    t = s + 56'sd32768;
    r = signed'(t[55:16]);
    if (r > 40'sd2147483647) return {1'b1, 32'h7FFF_FFFF};
    else if (r < -40'sd2147483648) return {1'b1, 32'h8000_0000};
    return {1'b0, r[31:0]};
  endfunction

  logic [4:0]  state_r, state_nxt;
  logic [3:0]  pts_r [NAX];
  logic [CW-1:0] n_use [NAX];
  logic [CW-1:0] n_cur, n_a;
  logic signed [31:0] q_r [NAX];

  logic [2:0]  ax_r, ax_nxt;
  logic [2:0]  a_r, a_nxt;
  logic [4:0]  c_r, c_nxt;
  logic signed [31:0] x_r, x_nxt;
  logic signed [31:0] first_r, first_nxt;
  logic signed [31:0] plo_r, plo_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic [LW-1:0] lo_r, lo_nxt;
  logic [LW-1:0] lo_arr_r [NAX];
  logic [16:0]   f_arr_r [NAX];
  logic          arr_we;
  logic [16:0]   f_wr;
  logic          adv;

  logic [16:0]   w_r, w_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic signed [55:0] acc_cn_r, acc_cn_nxt, acc_ct_r, acc_ct_nxt;
  logic [31:0]   res_cn_r, res_cn_nxt, res_ct_r, res_ct_nxt;
  logic [1:0]    res_st_r, res_st_nxt;

  logic          out_valid_r;
  logic [31:0]   out_cn_r, out_ct_r;
  logic [1:0]    out_st_r;
  logic          load_out;

  logic          in_acc, axis_bad, grid_bad;
  logic          ax_we;
  logic [AXW-1:0] ax_waddr, ax_raddr;
  logic [CW-1:0] ax_off;
  logic [31:0]   ax_rdata;
  logic signed [31:0] ax_rd;
  logic signed [31:0] x_clamp;
  logic signed [32:0] width33, wid_fl, diff33;

  logic          g_we;
  logic [GW-1:0] g_waddr;
  logic [63:0]   g_wdata, g_rdata;
  logic          inr;

  gi5_pkg::div_req_t div_req;
  gi5_pkg::div_rsp_t div_rsp;

  logic signed [17:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [50:0] prod;
  logic signed [55:0] prod_ext;
  logic          cbit;
  logic [16:0]   f_a, fac;
  logic [33:0]   rnd_sum;
  logic [32:0]   fin_cn, fin_ct;

  // axis counts in use
  always_comb begin
    for (int i = 0; i < NAX; i++) begin
      n_use[i] = used_count(pts_r[i]);
    end
  end
  assign n_cur = n_use[ax_r];
  assign n_a   = n_use[a_r];

  // input side decode
  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid & in_ready;
  assign axis_bad = (in_axis_select > 3'd4) || (in_entry_index >= 15'(AXIS_MAX));
  assign grid_bad = EW'(in_entry_index) >= EW'(GRID_WORDS);

  // axis table store
  assign ax_we    = in_acc && (in_opcode == gi5_pkg::OP_LOAD_AXIS) && !axis_bad;
  assign ax_waddr = AXW'(in_axis_select) * AXW'(AXIS_MAX) + AXW'(in_entry_index);

  always_comb begin
    case (state_r)
      S_AX_L:  ax_off = n_cur - CW'(1);
      S_SC_RD: ax_off = j_r;
      S_PT_LO: ax_off = CW'(lo_r);
      S_PT_HI: ax_off = CW'(lo_r) + CW'(1);
      default: ax_off = '0;
    endcase
  end
  assign ax_raddr = AXW'(ax_r) * AXW'(AXIS_MAX) + AXW'(ax_off);

  gi5_ram #(.DEPTH(NAX * AXIS_MAX), .WIDTH(32)) u_axis_ram (
    .clk    (clk),
    .we     (ax_we),
    .waddr  (ax_waddr),
    .wdata  (in_axis_value),
    .raddr  (ax_raddr),
    .rdata_r(ax_rdata)
  );
  assign ax_rd = signed'(ax_rdata);

  // coefficient grid store, CN in the upper half
  assign g_we    = in_acc && (in_opcode == gi5_pkg::OP_LOAD_GRID) && !grid_bad;
  assign g_waddr = GW'(in_entry_index);
  assign g_wdata = {in_cn_value, in_ct_value};

  gi5_ram #(.DEPTH(GRID_WORDS), .WIDTH(64)) u_grid_ram (
    .clk    (clk),
    .we     (g_we),
    .waddr  (g_waddr),
    .wdata  (g_wdata),
    .raddr  (idx_r[GW-1:0]),
    .rdata_r(g_rdata)
  );
  assign inr = idx_r < IW'(GRID_WORDS);

  // clamp, interval width and offset of the current axis
  assign x_clamp = (q_r[ax_r] < first_r) ? first_r :
                   ((q_r[ax_r] > ax_rd) ? ax_rd : q_r[ax_r]);
  assign width33 = {ax_rd[31], ax_rd} - {plo_r[31], plo_r};
  assign wid_fl  = (width33 < 33'sd1) ? 33'sd1 : width33;
  assign diff33  = {x_r[31], x_r} - {plo_r[31], plo_r};

  gi5_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  // shared multiplier operand select
  assign cbit = c_r[a_r];
  assign f_a  = f_arr_r[a_r];
  assign fac  = cbit ? f_a : (gi5_pkg::ONE_Q16 - f_a);

  always_comb begin
    case (state_r)
      S_W_MUL: begin
        mul_a = {1'b0, w_r};
        mul_b = {16'd0, fac};
      end
      S_CN_MUL: begin
        mul_a = {1'b0, w_r};
        mul_b = {g_rdata[63], g_rdata[63:32]};
      end
      S_CT_MUL: begin
        mul_a = {1'b0, w_r};
        mul_b = {g_rdata[31], g_rdata[31:0]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  gi5_mul u_mul (
    .clk   (clk),
    .a     (mul_a),
    .b     (mul_b),
    .prod_r(prod)
  );
  assign prod_ext = {{5{prod[50]}}, prod};
  assign rnd_sum  = prod[33:0] + 34'd32768;
  assign fin_cn   = finish_q16(acc_cn_r);
  assign fin_ct   = finish_q16(acc_ct_r);

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    ax_nxt     = ax_r;
    a_nxt      = a_r;
    c_nxt      = c_r;
    x_nxt      = x_r;
    first_nxt  = first_r;
    plo_nxt    = plo_r;
    j_nxt      = j_r;
    lo_nxt     = lo_r;
    w_nxt      = w_r;
    idx_nxt    = idx_r;
    acc_cn_nxt = acc_cn_r;
    acc_ct_nxt = acc_ct_r;
    res_cn_nxt = res_cn_r;
    res_ct_nxt = res_ct_r;
    res_st_nxt = res_st_r;
    arr_we     = 1'b0;
    f_wr       = '0;
    adv        = 1'b0;
    div_req.start = 1'b0;
    div_req.num   = diff33[31:0];
    div_req.den   = wid_fl[31:0];

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          res_cn_nxt = '0;
          res_ct_nxt = '0;
          res_st_nxt = gi5_pkg::ST_OK;
          state_nxt  = S_DONE;
          case (in_opcode)
            gi5_pkg::OP_LOAD_AXIS: begin
              if (axis_bad) res_st_nxt = gi5_pkg::ST_BAD_INDEX;
            end
            gi5_pkg::OP_LOAD_GRID: begin
              if (grid_bad) res_st_nxt = gi5_pkg::ST_BAD_INDEX;
            end
            gi5_pkg::OP_QUERY: begin
              ax_nxt     = '0;
              acc_cn_nxt = '0;
              acc_ct_nxt = '0;
              state_nxt  = S_AX_F;
            end
            default: ;
          endcase
        end
      end
      S_AX_F: state_nxt = S_AX_L;
      S_AX_L: begin
        first_nxt = ax_rd;
        state_nxt = S_AX_C;
      end
      S_AX_C: begin
        x_nxt = x_clamp;
        if (x_clamp <= first_r) begin
          lo_nxt    = '0;
          state_nxt = S_PT_LO;
        end else if (x_clamp >= ax_rd) begin
          lo_nxt    = LW'(n_cur - CW'(2));
          state_nxt = S_PT_LO;
        end else begin
          j_nxt     = CW'(1);
          state_nxt = S_SC_RD;
        end
      end
      S_SC_RD: state_nxt = S_SC_CMP;
      S_SC_CMP: begin
        if (ax_rd > x_r) begin
          lo_nxt    = LW'(j_r - CW'(1));
          state_nxt = S_PT_LO;
        end else if ((j_r + CW'(1)) < n_cur) begin
          j_nxt     = j_r + CW'(1);
          state_nxt = S_SC_RD;
        end else begin
          lo_nxt    = LW'(n_cur - CW'(2));
          state_nxt = S_PT_LO;
        end
      end
      S_PT_LO: state_nxt = S_PT_HI;
      S_PT_HI: begin
        plo_nxt   = ax_rd;
        state_nxt = S_PT_W;
      end
      S_PT_W: begin
        if (diff33 <= 33'sd0) begin
          f_wr   = '0;
          arr_we = 1'b1;
          adv    = 1'b1;
        end else if (diff33 >= wid_fl) begin
          f_wr   = gi5_pkg::ONE_Q16;
          arr_we = 1'b1;
          adv    = 1'b1;
        end else begin
          div_req.start = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          f_wr   = {1'b0, div_rsp.quot};
          arr_we = 1'b1;
          adv    = 1'b1;
        end
      end
      S_W_MUL: begin
        idx_nxt   = IW'(idx_r * IW'(n_a)) + IW'(lo_arr_r[a_r]) + IW'(cbit);
        state_nxt = S_W_RND;
      end
      S_W_RND: begin
        w_nxt = rnd_sum[32:16];
        if (a_r == 3'(NAX - 1)) begin
          state_nxt = S_CN_MUL;
        end else begin
          a_nxt     = a_r + 3'd1;
          state_nxt = S_W_MUL;
        end
      end
      S_CN_MUL: state_nxt = S_CT_MUL;
      S_CT_MUL: begin
        if (inr) acc_cn_nxt = acc_cn_r + prod_ext;
        state_nxt = S_CT_ACC;
      end
      S_CT_ACC: begin
        if (inr) acc_ct_nxt = acc_ct_r + prod_ext;
        if (c_r == 5'd31) begin
          state_nxt = S_FIN;
        end else begin
          c_nxt     = c_r + 5'd1;
          a_nxt     = '0;
          w_nxt     = gi5_pkg::ONE_Q16;
          idx_nxt   = '0;
          state_nxt = S_W_MUL;
        end
      end
      S_FIN: begin
        res_cn_nxt = fin_cn[31:0];
        res_ct_nxt = fin_ct[31:0];
        res_st_nxt = (fin_cn[32] | fin_ct[32]) ? gi5_pkg::ST_SAT : gi5_pkg::ST_OK;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase

    // next axis, or start the corner sweep after the last one
    if (adv) begin
      if (ax_r == 3'(NAX - 1)) begin
        a_nxt     = '0;
        c_nxt     = '0;
        w_nxt     = gi5_pkg::ONE_Q16;
        idx_nxt   = '0;
        state_nxt = S_W_MUL;
      end else begin
        ax_nxt    = ax_r + 3'd1;
        state_nxt = S_AX_F;
      end
    end
  end

  // output register
  assign load_out = (state_r == S_DONE) && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NAX; i++) begin
        pts_r[i] <= gi5_pkg::POINTS_RESET;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= load_out | (out_valid_r & ~out_ready);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          gi5_pkg::CFG_THETA:   pts_r[0] <= cfg_data;
          gi5_pkg::CFG_MACH:    pts_r[1] <= cfg_data;
          gi5_pkg::CFG_TAU:     pts_r[2] <= cfg_data;
          gi5_pkg::CFG_ALPHA_N: pts_r[3] <= cfg_data;
          gi5_pkg::CFG_ALPHA_T: pts_r[4] <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    ax_r     <= ax_nxt;
    a_r      <= a_nxt;
    c_r      <= c_nxt;
    x_r      <= x_nxt;
    first_r  <= first_nxt;
    plo_r    <= plo_nxt;
    j_r      <= j_nxt;
    lo_r     <= lo_nxt;
    w_r      <= w_nxt;
    idx_r    <= idx_nxt;
    acc_cn_r <= acc_cn_nxt;
    acc_ct_r <= acc_ct_nxt;
    res_cn_r <= res_cn_nxt;
    res_ct_r <= res_ct_nxt;
    res_st_r <= res_st_nxt;
    if (in_acc && (in_opcode == gi5_pkg::OP_QUERY)) begin
      q_r[0] <= in_query_theta;
      q_r[1] <= in_query_mach;
      q_r[2] <= in_query_tau;
      q_r[3] <= in_query_alpha_n;
      q_r[4] <= in_query_alpha_t;
    end
    if (arr_we) begin
      lo_arr_r[ax_r] <= lo_r;
      f_arr_r[ax_r]  <= f_wr;
    end
    if (load_out) begin
      out_cn_r <= res_cn_r;
      out_ct_r <= res_ct_r;
      out_st_r <= res_st_r;
    end
  end

  assign cfg_ready     = 1'b1;
  assign out_valid     = out_valid_r;
  assign out_cn_result = signed'(out_cn_r);
  assign out_ct_result = signed'(out_ct_r);
  assign out_status    = out_st_r;

endmodule

`default_nettype wire

// ===== rtl/gi5_checker.sv =====
// Port-level checker for grid_interpolator_5d, attached by bind.
// Depends on gi5_pkg and grid_interpolator_5d_defines.svh.
`default_nettype none

`include "grid_interpolator_5d_defines.svh"

module gi5_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_cn_result,
  input logic [31:0] out_ct_result,
  input logic [1:0]  out_status
);

  // a waiting result is never dropped
  `GI5_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result lost while stalled")

  // every accepted item takes the block out of idle, so in_ready drops after the transfer
  `GI5_ASSERT_NEXT(a_busy_after, in_valid && in_ready, !in_ready, "ready right after transfer")

  // only defined status codes reach the port
  `GI5_ASSERT_SAME(a_status_code, out_valid, out_status == gi5_pkg::ST_OK || out_status == gi5_pkg::ST_BAD_INDEX || out_status == gi5_pkg::ST_SAT, "undefined status")

  // a rejected load carries zero coefficients
  `GI5_ASSERT_SAME(a_bad_zero, out_valid && out_status == gi5_pkg::ST_BAD_INDEX, out_cn_result == 32'd0 && out_ct_result == 32'd0, "bad load with data")

endmodule

bind grid_interpolator_5d gi5_checker u_gi5_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_cn_result(out_cn_result),
  .out_ct_result(out_ct_result),
  .out_status   (out_status)
);

`default_nettype wire

// ===== bench/tb_grid_interpolator_5d.sv =====
// Self-checking testbench for grid_interpolator_5d: loads, queries, point counts.
// Depends on gi5_pkg and the grid_interpolator_5d RTL; a scoreboard class
// predicts every result, plain tasks drive the channels.
`timescale 1ns / 1ps

module tb_grid_interpolator_5d;

  localparam int          AXIS_MAX   = 8;
  localparam int          GRID_WORDS = 32768;
  localparam logic [1:0]  OP_UNUSED  = 2'd3;
  localparam int          RAND_ITEMS = 180;
  localparam int          PHASES     = 4;
  localparam longint      CYCLE_LIMIT = 4000000;
  localparam logic signed [31:0] Q_MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh80000000;

  typedef struct {
    logic [1:0]         opcode;
    logic [2:0]         axis_sel;
    logic [14:0]        entry;
    logic signed [31:0] axis_val;
    logic signed [31:0] cn_val;
    logic signed [31:0] ct_val;
    logic signed [31:0] coord [5];
  } gi_item_t;

  typedef struct {
    logic signed [31:0] cn;
    logic signed [31:0] ct;
    logic [1:0]         status;
  } gi_result_t;

  // Predicts the block's results and checks them in order
  class grid_scoreboard;
    logic signed [31:0] axis_tbl [5*AXIS_MAX];
    logic signed [31:0] cn_tbl [GRID_WORDS];
    logic signed [31:0] ct_tbl [GRID_WORDS];
    int unsigned        n_used [5];
    gi_result_t         pending [$];
    int                 errors;

    function new();
      foreach (n_used[a]) n_used[a] = 8;
      errors = 0;
    endfunction

    function void set_count(int a, logic [3:0] v);
      n_used[a] = (v < 2) ? 2 : ((v > AXIS_MAX) ? AXIS_MAX : v);
    endfunction

    function logic signed [31:0] round_sat(longint s, inout bit sat);
      longint r;
      r = (s + 32768) >>> 16;
      if (r > 64'sd2147483647) begin
        sat = 1;
        return Q_MAX;
      end
      if (r < -64'sd2147483648) begin
        sat = 1;
        return Q_MIN;
      end
      return r[31:0];
    endfunction

    function gi_result_t interpolate(gi_item_t it);
      gi_result_t r;
      int unsigned lo [5];
      longint unsigned frac [5];
      longint x, first, last, width, diff, scn, sct;
      longint unsigned q, w, fac, idx;
      int unsigned bsel;
      bit sat;
      sat = 0;
      scn = 0;
      sct = 0;
      // clamp, bracket and fraction per axis
      for (int a = 0; a < 5; a++) begin
        x = it.coord[a];
        first = axis_tbl[a*AXIS_MAX];
        last = axis_tbl[a*AXIS_MAX + n_used[a] - 1];
        if (x < first) x = first;
        else if (x > last) x = last;
        if (x <= first) lo[a] = 0;
        else if (x >= last) lo[a] = n_used[a] - 2;
        else begin
          lo[a] = n_used[a] - 2;
          for (int j = n_used[a] - 1; j >= 1; j--)
            if (longint'(axis_tbl[a*AXIS_MAX + j]) > x) lo[a] = j - 1;
        end
        width = longint'(axis_tbl[a*AXIS_MAX + lo[a] + 1]) -
                longint'(axis_tbl[a*AXIS_MAX + lo[a]]);
        if (width < 1) width = 1;
        diff = x - longint'(axis_tbl[a*AXIS_MAX + lo[a]]);
        if (diff <= 0) frac[a] = 0;
        else begin
          q = (longint'(diff) << 16) / longint'(width);
          frac[a] = (q > 65536) ? 65536 : q;
        end
      end
      // 32 corners, weights rounded factor by factor
      for (int c = 0; c < 32; c++) begin
        w = 65536;
        idx = 0;
        for (int a = 0; a < 5; a++) begin
          bsel = (c >> a) & 1;
          fac = bsel ? frac[a] : 65536 - frac[a];
          w = (w * fac + 32768) >> 16;
          idx = idx * n_used[a] + lo[a] + bsel;
        end
        if (idx < GRID_WORDS) begin
          scn += longint'(w) * longint'(cn_tbl[idx]);
          sct += longint'(w) * longint'(ct_tbl[idx]);
        end
      end
      r.cn = round_sat(scn, sat);
      r.ct = round_sat(sct, sat);
      r.status = sat ? gi5_pkg::ST_SAT : gi5_pkg::ST_OK;
      return r;
    endfunction

    function void note_input(gi_item_t it);
      gi_result_t r;
      r.cn = 0;
      r.ct = 0;
      r.status = gi5_pkg::ST_OK;
      case (it.opcode)
        gi5_pkg::OP_LOAD_AXIS: begin
          if (it.axis_sel > 4 || it.entry >= AXIS_MAX) r.status = gi5_pkg::ST_BAD_INDEX;
          else axis_tbl[it.axis_sel*AXIS_MAX + it.entry] = it.axis_val;
        end
        gi5_pkg::OP_LOAD_GRID: begin
          cn_tbl[it.entry] = it.cn_val;
          ct_tbl[it.entry] = it.ct_val;
        end
        gi5_pkg::OP_QUERY: r = interpolate(it);
        default: ;
      endcase
      pending.insert(pending.size(), r);
    endfunction

    function void check_result(logic signed [31:0] cn, logic signed [31:0] ct,
                               logic [1:0] status);
      gi_result_t e;
      if (pending.size() == 0) begin
        $error("result transfer with nothing expected");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (cn !== e.cn) begin
        $error("cn_result: expected %0d, got %0d", e.cn, cn);
        errors++;
      end
      if (ct !== e.ct) begin
        $error("ct_result: expected %0d, got %0d", e.ct, ct);
        errors++;
      end
      if (status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, status);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  logic [1:0] in_opcode = 0;
  logic [2:0] in_axis_select = 0;
  logic [14:0] in_entry_index = 0;
  logic signed [31:0] in_axis_value = 0, in_cn_value = 0, in_ct_value = 0;
  logic signed [31:0] in_query_theta = 0, in_query_mach = 0, in_query_tau = 0;
  logic signed [31:0] in_query_alpha_n = 0, in_query_alpha_t = 0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [31:0] out_cn_result, out_ct_result;
  logic [1:0] out_status;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [2:0] cfg_index = 0;
  logic [3:0] cfg_data = 0;

  grid_interpolator_5d dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_opcode(in_opcode), .in_axis_select(in_axis_select),
    .in_entry_index(in_entry_index), .in_axis_value(in_axis_value),
    .in_cn_value(in_cn_value), .in_ct_value(in_ct_value),
    .in_query_theta(in_query_theta), .in_query_mach(in_query_mach),
    .in_query_tau(in_query_tau), .in_query_alpha_n(in_query_alpha_n),
    .in_query_alpha_t(in_query_alpha_t),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_cn_result(out_cn_result), .out_ct_result(out_ct_result),
    .out_status(out_status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  grid_scoreboard sb = new();

  int          send_idle = 33;
  int          recv_idle = 54;
  bit          hold_req = 0;
  int          hold_left = 0;
  longint      cycles = 0;
  logic signed [31:0] axis_copy [5*AXIS_MAX];
  bit          grid_written [GRID_WORDS];
  int unsigned cur_n [5];

  always #10 clk = ~clk;

  // run-length guard
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL grid_interpolator_5d");
      $finish;
    end
  end

  // result side: random back-pressure plus one long hold-off
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = 700;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready = 0;
    end else begin
      out_ready = ($urandom_range(99) >= recv_idle);
    end
  end

  // result transfers
  always @(posedge clk)
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_cn_result, out_ct_result, out_status);

  task automatic send_item(gi_item_t it);
    while ($urandom_range(99) < send_idle) begin
      in_valid = 0;
      @(negedge clk);
    end
    in_opcode = it.opcode;
    in_axis_select = it.axis_sel;
    in_entry_index = it.entry;
    in_axis_value = it.axis_val;
    in_cn_value = it.cn_val;
    in_ct_value = it.ct_val;
    in_query_theta = it.coord[0];
    in_query_mach = it.coord[1];
    in_query_tau = it.coord[2];
    in_query_alpha_n = it.coord[3];
    in_query_alpha_t = it.coord[4];
    in_valid = 1;
    do @(posedge clk); while (!in_ready);
    sb.note_input(it);
    @(negedge clk);
  endtask

  function automatic gi_item_t noise_item(logic [1:0] op);
    gi_item_t it;
    it.opcode = op;
    it.axis_sel = 3'($urandom_range(7));
    it.entry = 15'($urandom);
    it.axis_val = $urandom;
    it.cn_val = $urandom;
    it.ct_val = $urandom;
    foreach (it.coord[a]) it.coord[a] = $urandom;
    return it;
  endfunction

  task automatic load_axis(int a, int i, logic signed [31:0] v);
    gi_item_t it;
    it = noise_item(gi5_pkg::OP_LOAD_AXIS);
    it.axis_sel = 3'(a);
    it.entry = 15'(i);
    it.axis_val = v;
    axis_copy[a*AXIS_MAX + i] = v;
    send_item(it);
  endtask

  task automatic load_grid(int idx, logic signed [31:0] cn, logic signed [31:0] ct);
    gi_item_t it;
    it = noise_item(gi5_pkg::OP_LOAD_GRID);
    it.entry = 15'(idx);
    it.cn_val = cn;
    it.ct_val = ct;
    grid_written[idx] = 1;
    send_item(it);
  endtask

  function automatic logic signed [31:0] grid_value();
    case ($urandom_range(5))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return $urandom;
      default: return 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
    endcase
  endfunction

  // non-decreasing table; the wide form spans the whole Q16.16 range
  task automatic fill_axis(int a, bit wide);
    longint v;
    v = wide ? -64'sd2147483648 : longint'($urandom_range(0, 1 << 21)) - (1 << 20);
    for (int i = 0; i < AXIS_MAX; i++) begin
      if (wide && i == AXIS_MAX - 1) v = 64'sd2147483647;
      load_axis(a, i, v[31:0]);
      if ($urandom_range(4) != 0)
        v += wide ? longint'($urandom_range(1, 1 << 29)) : $urandom_range(1, 1 << 18);
    end
  endtask

  // every corner a query may read gets written first
  task automatic prefill_grid();
    int unsigned words;
    words = 1;
    foreach (cur_n[a]) words *= cur_n[a];
    for (int i = 0; i < words; i++)
      if (!grid_written[i]) load_grid(i, grid_value(), grid_value());
  endtask

  function automatic logic signed [31:0] pick_coord(int a);
    longint first, last, v;
    first = axis_copy[a*AXIS_MAX];
    last = axis_copy[a*AXIS_MAX + cur_n[a] - 1];
    case ($urandom_range(9))
      0: return $urandom;
      1: return axis_copy[a*AXIS_MAX + $urandom_range(cur_n[a] - 1)];
      2: return ($urandom_range(1)) ? Q_MAX : Q_MIN;
      default: begin
        v = first - 500 + longint'({$urandom, $urandom} % (last - first + 1001));
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return v[31:0];
      end
    endcase
  endfunction

  function automatic gi_item_t query_item();
    gi_item_t it;
    it = noise_item(gi5_pkg::OP_QUERY);
    foreach (it.coord[a]) it.coord[a] = pick_coord(a);
    return it;
  endfunction

  task automatic wait_drained();
    in_valid = 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_count(logic [2:0] idx, logic [3:0] v);
    cfg_index = idx;
    cfg_data = v;
    cfg_valid = 1;
    do @(posedge clk); while (!cfg_ready);
    sb.set_count(idx, v);
    cur_n[idx] = (v < 2) ? 2 : ((v > AXIS_MAX) ? AXIS_MAX : v);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  task automatic set_counts(logic [3:0] t, logic [3:0] m, logic [3:0] u,
                            logic [3:0] n, logic [3:0] p);
    wait_drained();
    write_count(gi5_pkg::CFG_THETA, t);
    write_count(gi5_pkg::CFG_MACH, m);
    write_count(gi5_pkg::CFG_TAU, u);
    write_count(gi5_pkg::CFG_ALPHA_N, n);
    write_count(gi5_pkg::CFG_ALPHA_T, p);
  endtask

  initial begin
    gi_item_t it;
    int rand_done;
    int r;
    foreach (cur_n[a]) cur_n[a] = 8;
    rand_done = 0;
    repeat (9) @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    set_counts(4'd2, 4'd2, 4'd2, 4'd2, 4'd2);
    for (int a = 0; a < 5; a++) fill_axis(a, 0);

    // directed: saturating grid, extreme, interior and on-point coordinates, bad loads, unused opcode
    for (int i = 0; i < 32; i++) load_grid(i, Q_MAX, Q_MIN);
    it = query_item();
    foreach (it.coord[a]) it.coord[a] = Q_MIN;
    send_item(it);
    foreach (it.coord[a]) it.coord[a] = Q_MAX;
    send_item(it);
    foreach (it.coord[a]) it.coord[a] = axis_copy[a*AXIS_MAX] + 7;
    send_item(it);
    foreach (it.coord[a]) it.coord[a] = axis_copy[a*AXIS_MAX + 1];
    send_item(it);
    it = noise_item(gi5_pkg::OP_LOAD_AXIS);
    it.axis_sel = 3'd5;
    it.entry = 0;
    send_item(it);
    it.axis_sel = 3'd7;
    it.entry = 15'h7FFF;
    send_item(it);
    it.axis_sel = 3'd0;
    it.entry = 15'(AXIS_MAX);
    send_item(it);
    send_item(noise_item(OP_UNUSED));
    load_grid(GRID_WORDS - 1, Q_MIN, Q_MAX);
    load_grid(0, 0, 0);
    send_item(query_item());
    for (int i = 1; i < 32; i++) load_grid(i, grid_value(), grid_value());

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        1: set_counts(4'd15, 4'd1, 4'd2, 4'd0, 4'd2);
        2: set_counts(4'd2, 4'd2, 4'd3, 4'd2, 4'd8);
        3: begin
          set_counts(4'd3, 4'd3, 4'd2, 4'd9, 4'd2);
          fill_axis(0, 1);
        end
        default: ;
      endcase
      prefill_grid();
      for (int k = 0; k < RAND_ITEMS / PHASES; k++) begin
        // idle mix: sender-light first, then receiver-light, then none
        if (rand_done < RAND_ITEMS / 3) begin
          send_idle = 33;
          recv_idle = 54;
        end else if (rand_done < 2 * RAND_ITEMS / 3) begin
          send_idle = 54;
          recv_idle = 33;
        end else begin
          send_idle = 0;
          recv_idle = 0;
        end
        if (rand_done == 20) hold_req = 1;
        r = $urandom_range(99);
        if (r < 62) it = query_item();
        else if (r < 84) begin
          it = noise_item(gi5_pkg::OP_LOAD_GRID);
          it.cn_val = grid_value();
          it.ct_val = grid_value();
        end else if (r < 92) it = noise_item(gi5_pkg::OP_LOAD_AXIS);
        else if (r < 96) begin
          it = noise_item(gi5_pkg::OP_LOAD_AXIS);
          it.axis_sel = 3'($urandom_range(5, 7));
        end else it = noise_item(OP_UNUSED);
        if (it.opcode == gi5_pkg::OP_LOAD_AXIS && it.axis_sel <= 4 && it.entry < AXIS_MAX)
          axis_copy[it.axis_sel*AXIS_MAX + it.entry] = it.axis_val;
        send_item(it);
        rand_done++;
      end
    end

    wait_drained();
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("PASS grid_interpolator_5d");
    else
      $display("FAIL grid_interpolator_5d");
    $finish;
  end

endmodule

// ===== grid_interpolator_5d.f =====
+incdir+rtl
rtl/gi5_pkg.sv
rtl/gi5_ram.sv
rtl/gi5_div.sv
rtl/gi5_mul.sv
rtl/grid_interpolator_5d.sv
rtl/gi5_checker.sv
bench/tb_grid_interpolator_5d.sv
